/* design/llne_pkg.sv */
// ----------------------------------------------------------------------------
// Login-name line editor: shared types and constants
// Character codes, command classes, result codes and the structs passed
// between the front end, the command queue and the back end.
// ----------------------------------------------------------------------------
package llne_pkg;

   localparam int CH_W      = 7;
   localparam int BYTE_W    = 8;
   localparam int KIND_W    = 2;
   localparam int OUTC_W    = 2;
   localparam int LEN_W     = 5;
   localparam int CLS_W     = 3;
   localparam int CSR_IDX_W = 1;

   // Character codes
   localparam logic [CH_W-1:0] CH_NUL       = 7'h00;
   localparam logic [CH_W-1:0] CH_EOT       = 7'h04;
   localparam logic [CH_W-1:0] CH_LF        = 7'h0A;
   localparam logic [CH_W-1:0] CH_CR        = 7'h0D;
   localparam logic [CH_W-1:0] CH_UPPER_A   = 7'h41;
   localparam logic [CH_W-1:0] CH_UPPER_Z   = 7'h5A;
   localparam logic [CH_W-1:0] CH_LOWER_A   = 7'h61;
   localparam logic [CH_W-1:0] CH_LOWER_Z   = 7'h7A;
   localparam logic [CH_W-1:0] CASE_OFFSET  = 7'h20;
   localparam logic [CH_W-1:0] ERASE_RESET  = 7'h08;
   localparam logic [CH_W-1:0] KILL_RESET   = 7'h40;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ERASE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KILL  = 1'd1;

   // Command classes decided by the front end
   localparam logic [CLS_W-1:0] CLS_PLAIN  = 3'd0;
   localparam logic [CLS_W-1:0] CLS_BREAK  = 3'd1;
   localparam logic [CLS_W-1:0] CLS_HANGUP = 3'd2;
   localparam logic [CLS_W-1:0] CLS_EOL    = 3'd3;
   localparam logic [CLS_W-1:0] CLS_LOWER  = 3'd4;
   localparam logic [CLS_W-1:0] CLS_UPPER  = 3'd5;
   localparam logic [CLS_W-1:0] CLS_ERASE  = 3'd6;
   localparam logic [CLS_W-1:0] CLS_KILL   = 3'd7;

   // Result item kinds
   localparam logic [KIND_W-1:0] KIND_ECHO    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_NAME    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_OUTCOME = 2'd2;

   // Outcome codes
   localparam logic [OUTC_W-1:0] OUTC_ACCEPT = 2'd0;
   localparam logic [OUTC_W-1:0] OUTC_RETRY  = 2'd1;
   localparam logic [OUTC_W-1:0] OUTC_BREAK  = 2'd2;
   localparam logic [OUTC_W-1:0] OUTC_HANGUP = 2'd3;

   typedef struct packed {
      logic [CLS_W-1:0]  cls;
      logic [CH_W-1:0]   ch;
      logic [BYTE_W-1:0] echo;
      logic              is_cr;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] item_kind;
      logic [BYTE_W-1:0] out_byte;
      logic [OUTC_W-1:0] outcome;
      logic [LEN_W-1:0]  name_length;
      logic              cr_mode;
      logic              lowercase_terminal;
      logic              last_of_run;
   } rsp_type;

   // Seven-bit character with an even parity bit in bit 7.
   function automatic logic [BYTE_W-1:0] with_parity(input logic [CH_W-1:0] c);
      return {^c, c};
   endfunction

endpackage

/* design/llne_ifs.sv */
// ----------------------------------------------------------------------------
// Login-name line editor: channel interfaces
// Valid/ready channels for received bytes and for result items.
// ----------------------------------------------------------------------------
interface llne_req_if;
   logic                      valid;
   logic                      ready;
   logic [llne_pkg::BYTE_W-1:0] received_byte;

   modport source (output valid, output received_byte, input ready);
   modport sink   (input valid, input received_byte, output ready);
endinterface

interface llne_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [llne_pkg::KIND_W-1:0] item_kind;
   logic [llne_pkg::BYTE_W-1:0] out_byte;
   logic [llne_pkg::OUTC_W-1:0] outcome;
   logic [llne_pkg::LEN_W-1:0]  name_length;
   logic                        cr_mode;
   logic                        lowercase_terminal;
   logic                        last_of_run;

   modport source (output valid, output item_kind, output out_byte, output outcome,
                   output name_length, output cr_mode, output lowercase_terminal,
                   output last_of_run, input ready);
   modport sink   (input valid, input item_kind, input out_byte, input outcome,
                   input name_length, input cr_mode, input lowercase_terminal,
                   input last_of_run, output ready);
endinterface

/* design/llne_front.sv */
// ----------------------------------------------------------------------------
// Login-name line editor: front end
// Holds the erase and kill registers, accepts received bytes and classifies
// each one into a command for the back end.
// ----------------------------------------------------------------------------
module llne_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [llne_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [llne_pkg::CH_W-1:0]        csr_wdata,
   llne_req_if.sink                         req_ch,
   output logic                             cmd_valid,
   input  logic                             cmd_ready,
   output llne_pkg::cmd_type                cmd
);

   logic [llne_pkg::CH_W-1:0] erase_ff, erase_in;
   logic [llne_pkg::CH_W-1:0] kill_ff, kill_in;
   logic                      hold_vld_ff, hold_vld_in;
   llne_pkg::cmd_type         hold_cmd_ff, hold_cmd_in;
   llne_pkg::cmd_type         cls_cmd;
   logic [llne_pkg::CH_W-1:0] c;
   logic                      take;

   assign c    = req_ch.received_byte[llne_pkg::CH_W-1:0];
   assign take = req_ch.valid && req_ch.ready;

   // Letters take precedence over the erase and kill characters.
   always_comb begin
      cls_cmd.cls   = llne_pkg::CLS_PLAIN;
      cls_cmd.ch    = c;
      cls_cmd.echo  = llne_pkg::with_parity(c);
      cls_cmd.is_cr = (c == llne_pkg::CH_CR);
      if (c == llne_pkg::CH_NUL) begin
         cls_cmd.cls = llne_pkg::CLS_BREAK;
      end else if (c == llne_pkg::CH_EOT) begin
         cls_cmd.cls = llne_pkg::CLS_HANGUP;
      end else if (c == llne_pkg::CH_CR || c == llne_pkg::CH_LF) begin
         cls_cmd.cls = llne_pkg::CLS_EOL;
      end else if (c >= llne_pkg::CH_LOWER_A && c <= llne_pkg::CH_LOWER_Z) begin
         cls_cmd.cls = llne_pkg::CLS_LOWER;
      end else if (c >= llne_pkg::CH_UPPER_A && c <= llne_pkg::CH_UPPER_Z) begin
         cls_cmd.cls = llne_pkg::CLS_UPPER;
         cls_cmd.ch  = c + llne_pkg::CASE_OFFSET;
      end else if (c == erase_ff) begin
         cls_cmd.cls = llne_pkg::CLS_ERASE;
      end else if (c == kill_ff) begin
         cls_cmd.cls = llne_pkg::CLS_KILL;
      end
   end

   always_comb begin
      erase_in    = erase_ff;
      kill_in     = kill_ff;
      hold_vld_in = hold_vld_ff;
      hold_cmd_in = hold_cmd_ff;
      if (csr_wr_en) begin
         case (csr_index)
            llne_pkg::CSR_ERASE: erase_in = csr_wdata;
            llne_pkg::CSR_KILL:  kill_in  = csr_wdata;
            default: ;
         endcase
      end
      if (hold_vld_ff && cmd_ready) begin
         hold_vld_in = 1'b0;
      end
      if (take) begin
         hold_vld_in = 1'b1;
         hold_cmd_in = cls_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         erase_ff    <= llne_pkg::ERASE_RESET;
         kill_ff     <= llne_pkg::KILL_RESET;
         hold_vld_ff <= 1'b0;
      end else begin
         erase_ff    <= erase_in;
         kill_ff     <= kill_in;
         hold_vld_ff <= hold_vld_in;
      end
      hold_cmd_ff <= hold_cmd_in;
   end

   assign req_ch.ready = !hold_vld_ff || cmd_ready;
   assign cmd_valid    = hold_vld_ff;
   assign cmd          = hold_cmd_ff;

endmodule

/* design/llne_fifo.sv */
// ----------------------------------------------------------------------------
// Login-name line editor: command queue
// Two-entry queue of classified commands between the front and back ends.
// ----------------------------------------------------------------------------
module llne_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  llne_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop,
   output llne_pkg::cmd_type pop_cmd
);

   llne_pkg::cmd_type entries_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_cmd    = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* design/llne_back.sv */
// ----------------------------------------------------------------------------
// Login-name line editor: back end
// Carries out commands against the name store and the letter flags, and
// produces result items through a registered output stage.
// ----------------------------------------------------------------------------
module llne_back #(
   parameter int NAME_CAPACITY = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  llne_pkg::cmd_type q_cmd,
   output logic              q_pop,
   llne_rsp_if.source        rsp_ch
);

   localparam int CNT_W = $clog2(NAME_CAPACITY + 1);
   localparam int IDX_W = (NAME_CAPACITY > 1) ? $clog2(NAME_CAPACITY) : 1;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(NAME_CAPACITY);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_NAME    = 3'd1;
   localparam logic [2:0] ST_OUTCOME = 3'd2;
   localparam logic [2:0] ST_KILL_CR = 3'd3;
   localparam logic [2:0] ST_KILL_LF = 3'd4;

   logic [llne_pkg::CH_W-1:0] store_mem [NAME_CAPACITY];
   logic [llne_pkg::CH_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]          rd_addr;
   logic                      wr_en;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] emit_ff, emit_in;
   logic             saw_upper_ff, saw_upper_in;
   logic             saw_lower_ff, saw_lower_in;
   logic             cr_ff, cr_in;
   logic             rsp_vld_ff, rsp_vld_in;
   llne_pkg::rsp_type rsp_ff, rsp_in;
   llne_pkg::rsp_type item;
   logic             load, adv;
   logic [CNT_W+llne_pkg::LEN_W-1:0] len_ext;

   assign adv     = !rsp_vld_ff || rsp_ch.ready;
   assign len_ext = {{llne_pkg::LEN_W{1'b0}}, fill_ff};

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      emit_in      = emit_ff;
      saw_upper_in = saw_upper_ff;
      saw_lower_in = saw_lower_ff;
      cr_in        = cr_ff;
      load         = 1'b0;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      rd_addr      = emit_ff[IDX_W-1:0];
      item         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid && adv) begin
               q_pop = 1'b1;
               if (q_cmd.cls == llne_pkg::CLS_BREAK || q_cmd.cls == llne_pkg::CLS_HANGUP) begin
                  load           = 1'b1;
                  item.item_kind = llne_pkg::KIND_OUTCOME;
                  item.outcome   = (q_cmd.cls == llne_pkg::CLS_BREAK) ?
                                   llne_pkg::OUTC_BREAK : llne_pkg::OUTC_HANGUP;
                  item.last_of_run = 1'b1;
                  fill_in      = '0;
                  saw_upper_in = 1'b0;
                  saw_lower_in = 1'b0;
               end else if (q_cmd.cls == llne_pkg::CLS_EOL || fill_ff >= CAP_CNT) begin
                  // The first store read is issued now so that its data is
                  // ready when the name walk starts.
                  cr_in    = q_cmd.is_cr;
                  emit_in  = '0;
                  rd_addr  = '0;
                  state_in = (fill_ff == '0) ? ST_OUTCOME : ST_NAME;
               end else begin
                  load             = 1'b1;
                  item.item_kind   = llne_pkg::KIND_ECHO;
                  item.out_byte    = q_cmd.echo;
                  item.last_of_run = 1'b1;
                  if (q_cmd.cls == llne_pkg::CLS_ERASE) begin
                     if (fill_ff != '0) begin
                        fill_in = fill_ff - CNT_ONE;
                     end
                  end else if (q_cmd.cls == llne_pkg::CLS_KILL) begin
                     fill_in          = '0;
                     item.last_of_run = 1'b0;
                     state_in         = ST_KILL_CR;
                  end else begin
                     if (q_cmd.cls == llne_pkg::CLS_LOWER) begin
                        saw_lower_in = 1'b1;
                     end
                     if (q_cmd.cls == llne_pkg::CLS_UPPER) begin
                        saw_upper_in = 1'b1;
                     end
                     wr_en   = 1'b1;
                     fill_in = fill_ff + CNT_ONE;
                  end
               end
            end
         end
         ST_NAME: begin
            if (adv) begin
               load           = 1'b1;
               item.item_kind = llne_pkg::KIND_NAME;
               item.out_byte  = {1'b0, rd_data_ff};
               emit_in        = emit_ff + CNT_ONE;
               rd_addr        = emit_in[IDX_W-1:0];
               if (emit_in == fill_ff) begin
                  state_in = ST_OUTCOME;
               end
            end
         end
         ST_OUTCOME: begin
            if (adv) begin
               load                    = 1'b1;
               item.item_kind          = llne_pkg::KIND_OUTCOME;
               item.outcome            = (saw_upper_ff || saw_lower_ff) ?
                                         llne_pkg::OUTC_ACCEPT : llne_pkg::OUTC_RETRY;
               item.name_length        = len_ext[llne_pkg::LEN_W-1:0];
               item.cr_mode            = cr_ff;
               item.lowercase_terminal = saw_upper_ff && !saw_lower_ff;
               item.last_of_run        = 1'b1;
               fill_in      = '0;
               saw_upper_in = 1'b0;
               saw_lower_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         ST_KILL_CR: begin
            if (adv) begin
               load           = 1'b1;
               item.item_kind = llne_pkg::KIND_ECHO;
               item.out_byte  = llne_pkg::with_parity(llne_pkg::CH_CR);
               state_in       = ST_KILL_LF;
            end
         end
         ST_KILL_LF: begin
            if (adv) begin
               load             = 1'b1;
               item.item_kind   = llne_pkg::KIND_ECHO;
               item.out_byte    = llne_pkg::with_parity(llne_pkg::CH_LF);
               item.last_of_run = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      rsp_in     = rsp_ff;
      if (rsp_vld_ff && rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end
      if (load) begin
         rsp_vld_in = 1'b1;
         rsp_in     = item;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[fill_ff[IDX_W-1:0]] <= q_cmd.ch;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         saw_upper_ff <= 1'b0;
         saw_lower_ff <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         saw_upper_ff <= saw_upper_in;
         saw_lower_ff <= saw_lower_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
      emit_ff <= emit_in;
      cr_ff   <= cr_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_ch.valid              = rsp_vld_ff;
   assign rsp_ch.item_kind          = rsp_ff.item_kind;
   assign rsp_ch.out_byte           = rsp_ff.out_byte;
   assign rsp_ch.outcome            = rsp_ff.outcome;
   assign rsp_ch.name_length        = rsp_ff.name_length;
   assign rsp_ch.cr_mode            = rsp_ff.cr_mode;
   assign rsp_ch.lowercase_terminal = rsp_ff.lowercase_terminal;
   assign rsp_ch.last_of_run        = rsp_ff.last_of_run;

   a_fill_within_capacity: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CAP_CNT)
      else $error("fill count beyond name capacity");

   a_walk_within_fill: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_NAME |-> emit_ff < fill_ff)
      else $error("name walk past the stored characters");

   a_clear_after_outcome: assert property (@(posedge clock) disable iff (reset)
      (load && item.item_kind == llne_pkg::KIND_OUTCOME)
      |=> (fill_ff == '0 && !saw_upper_ff && !saw_lower_ff))
      else $error("state not cleared after an outcome item");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE && q_valid))
      else $error("command taken while a run is in progress");

endmodule

/* design/login_name_line_editor_core.sv */
// ----------------------------------------------------------------------------
// Login-name line editor core
// Echoes and edits received terminal bytes and collects a login name.
// ----------------------------------------------------------------------------
// Each received byte produces its result items at one item per cycle while
// the result channel is ready, once the back end reaches it: an ordinary
// character or an erase gives one echo item, a kill three items, a break or
// hangup one outcome item, and an end of name a step to start the name store
// read, one name item per stored character and one outcome item, so at most
// NAME_CAPACITY name items. The back end works through one command at a time
// and reads the name store through a single registered read port; a two-entry
// command queue lets bytes keep arriving while a run is emitted.
module login_name_line_editor_core #(
   parameter int NAME_CAPACITY = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [llne_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [llne_pkg::CH_W-1:0]      csr_wdata,
   llne_req_if.sink                       req_ch,
   llne_rsp_if.source                     rsp_ch
);

   logic              fr_valid, fr_ready;
   llne_pkg::cmd_type fr_cmd;
   logic              q_valid, q_pop;
   llne_pkg::cmd_type q_cmd;

   llne_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .cmd_valid (fr_valid),
      .cmd_ready (fr_ready),
      .cmd       (fr_cmd)
   );

   llne_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_cmd   (fr_cmd),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_cmd    (q_cmd)
   );

   llne_back #(
      .NAME_CAPACITY (NAME_CAPACITY)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_cmd   (q_cmd),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// Login-name line editor core: self-checking testbench
// Sends received terminal bytes through the request channel and checks every
// echo, name and outcome item against a cycle-free prediction of the editor.
// A short directed table covers breaks, hangups, empty names, extremes and
// the editing characters. Random name attempts follow under several
// erase/kill settings. Both channels idle at random, and the result side
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
   import llne_pkg::*;

   localparam int NAME_CAP    = 16;
   localparam int IDLE_WAIT   = NAME_CAP + 4;
   localparam int HOLD_CYCLES = 300;
   localparam int RUN_LIMIT   = 400000;
   localparam int PHASE_BYTES = 48;
   localparam int NUM_PHASES  = 7;
   localparam int DIR_ROWS    = 22;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      logic [BYTE_W-1:0] in_byte;
      bit                typed;
      rsp_type           want;
   } keystroke_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CH_W-1:0]      csr_wdata;

   llne_req_if req_bus ();
   llne_rsp_if rsp_bus ();

   login_name_line_editor_core #(
      .NAME_CAPACITY (NAME_CAP)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predicted editor state and register copies.
   logic [CH_W-1:0] name_mem [NAME_CAP];
   logic [LEN_W-1:0] fill_cnt = '0;
   bit seen_upper = 1'b0;
   bit seen_lower = 1'b0;
   logic [CH_W-1:0] erase_cfg = ERASE_RESET;
   logic [CH_W-1:0] kill_cfg  = KILL_RESET;

   rsp_type line_items_due [$];
   rsp_type seen_item;
   rsp_type due_item;

   int cycle_count    = 0;
   int mismatch_count = 0;
   int bytes_sent     = 0;
   int items_checked  = 0;
   int settings_used  = 1;
   int burst_left     = 4;
   int outcome_seen [4] = '{0, 0, 0, 0};

   bit hold_go   = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;

   keystroke_row_type keystrokes [DIR_ROWS];
   logic [CH_W-1:0] erase_plan [NUM_PHASES] = '{7'h08, 7'h00, 7'h7F, 7'h61, 7'h15, 7'h0D, 7'h00};
   logic [CH_W-1:0] kill_plan  [NUM_PHASES] = '{7'h40, 7'h7F, 7'h00, 7'h41, 7'h15, 7'h0A, 7'h00};

   function automatic rsp_type make_item(input logic [KIND_W-1:0] kind,
                                         input logic [BYTE_W-1:0] b,
                                         input logic [OUTC_W-1:0] outc,
                                         input logic [LEN_W-1:0]  len,
                                         input logic cr, input logic lc,
                                         input logic last);
      rsp_type r;
      r.item_kind          = kind;
      r.out_byte           = b;
      r.outcome            = outc;
      r.name_length        = len;
      r.cr_mode            = cr;
      r.lowercase_terminal = lc;
      r.last_of_run        = last;
      return r;
   endfunction

   function automatic logic [BYTE_W-1:0] echo_code(input logic [CH_W-1:0] c);
      logic p;
      p = 1'b0;
      for (int i = 0; i < CH_W; i++) p = p ^ c[i];
      return {p, c};
   endfunction

   function automatic string describe(input rsp_type r);
      return $sformatf("kind %0d byte %h outcome %0d len %0d cr %0b lc %0b last %0b",
                       r.item_kind, r.out_byte, r.outcome, r.name_length,
                       r.cr_mode, r.lowercase_terminal, r.last_of_run);
   endfunction

   // Works out the items one accepted byte causes and advances the state.
   task automatic apply_keystroke(input logic [BYTE_W-1:0] raw);
      rsp_type run [$];
      logic [CH_W-1:0] c;
      bit store_it;
      int i;
      c = raw[CH_W-1:0];
      store_it = 1'b0;
      if (c == CH_NUL || c == CH_EOT) begin
         run.push_back(make_item(KIND_OUTCOME, '0, (c == CH_NUL) ? OUTC_BREAK : OUTC_HANGUP,
                                 '0, 1'b0, 1'b0, 1'b0));
         fill_cnt = '0;
         seen_upper = 1'b0;
         seen_lower = 1'b0;
      end else if (c == CH_CR || c == CH_LF || fill_cnt >= NAME_CAP) begin
         for (i = 0; i < fill_cnt; i++)
            run.push_back(make_item(KIND_NAME, {1'b0, name_mem[i]}, '0, '0, 1'b0, 1'b0, 1'b0));
         run.push_back(make_item(KIND_OUTCOME, '0,
                                 (seen_upper || seen_lower) ? OUTC_ACCEPT : OUTC_RETRY,
                                 fill_cnt, c == CH_CR, seen_upper && !seen_lower, 1'b0));
         fill_cnt = '0;
         seen_upper = 1'b0;
         seen_lower = 1'b0;
      end else begin
         run.push_back(make_item(KIND_ECHO, echo_code(c), '0, '0, 1'b0, 1'b0, 1'b0));
         if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            seen_lower = 1'b1;
            store_it = 1'b1;
         end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            seen_upper = 1'b1;
            c = c + CASE_OFFSET;
            store_it = 1'b1;
         end else if (c == erase_cfg) begin
            if (fill_cnt != 0) fill_cnt = fill_cnt - LEN_W'(1);
         end else if (c == kill_cfg) begin
            run.push_back(make_item(KIND_ECHO, echo_code(CH_CR), '0, '0, 1'b0, 1'b0, 1'b0));
            run.push_back(make_item(KIND_ECHO, echo_code(CH_LF), '0, '0, 1'b0, 1'b0, 1'b0));
            fill_cnt = '0;
         end else begin
            store_it = 1'b1;
         end
         if (store_it && fill_cnt < NAME_CAP) begin
            name_mem[fill_cnt] = c;
            fill_cnt = fill_cnt + LEN_W'(1);
         end
      end
      run[run.size()-1].last_of_run = 1'b1;
      foreach (run[k]) line_items_due.push_back(run[k]);
   endtask

   // Offers one byte and returns at the edge where it is taken. The sender
   // works in bursts; valid is only lowered when a gap follows.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed, input rsp_type want);
      int gap;
      req_bus.valid <= 1'b1;
      req_bus.received_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      apply_keystroke(b);
      if (typed) begin
         void'(line_items_due.pop_back());
         line_items_due.push_back(want);
      end
      bytes_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   function automatic logic [BYTE_W-1:0] pick_char();
      logic [CH_W-1:0] c;
      case ($urandom_range(0, 9))
         0, 1, 2, 9: c = CH_LOWER_A + CH_W'($urandom_range(0, 25));
         3, 4:       c = CH_UPPER_A + CH_W'($urandom_range(0, 25));
         5:          c = CH_W'($urandom_range(8'h20, 8'h7E));
         6: begin
            c = CH_W'($urandom_range(1, 127));
            if (c == CH_EOT || c == CH_CR || c == CH_LF) c = 7'h7F;
         end
         7:          c = erase_cfg;
         default:    c = ($urandom_range(0, 2) == 0) ? kill_cfg : erase_cfg;
      endcase
      return {1'($urandom_range(0, 1)), c};
   endfunction

   // One login attempt: mostly a name and a line end, sometimes a long name
   // that fills the store, sometimes cut short by a break or hangup.
   task automatic send_attempt();
      int len;
      int k;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 18) : $urandom_range(0, 8);
      for (k = 0; k < len; k++) send_byte(pick_char(), 1'b0, '0);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: send_byte({1'($urandom_range(0, 1)), CH_CR}, 1'b0, '0);
         5, 6, 7:       send_byte({1'($urandom_range(0, 1)), CH_LF}, 1'b0, '0);
         8: send_byte({1'($urandom_range(0, 1)), $urandom_range(0, 1) ? CH_NUL : CH_EOT},
                      1'b0, '0);
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (line_items_due.size() != 0) @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic set_registers(input logic [CH_W-1:0] erase_v, input logic [CH_W-1:0] kill_v);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_ERASE;
      csr_wdata <= erase_v;
      @(posedge clock);
      csr_index <= CSR_KILL;
      csr_wdata <= kill_v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      erase_cfg = erase_v;
      kill_cfg  = kill_v;
      @(posedge clock);
   endtask

   // Result side: a long hold-off once requested, otherwise a stall pattern
   // that moves through four modes, including stretches of no stalling.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_go && !hold_done) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         case ((cycle_count / 97) % 4)
            0:       rsp_bus.ready <= 1'b1;
            1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
            2:       rsp_bus.ready <= (cycle_count % 7) > 2;
            default: rsp_bus.ready <= $urandom_range(0, 3) != 0;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen_item = make_item(rsp_bus.item_kind, rsp_bus.out_byte, rsp_bus.outcome,
                               rsp_bus.name_length, rsp_bus.cr_mode,
                               rsp_bus.lowercase_terminal, rsp_bus.last_of_run);
         items_checked++;
         if (line_items_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("[%0d] unexpected item: %s", cycle_count, describe(seen_item));
         end else begin
            due_item = line_items_due.pop_front();
            if (seen_item !== due_item) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("[%0d] item mismatch", cycle_count);
                  $display("   expected %s", describe(due_item));
                  $display("   actual   %s", describe(seen_item));
               end
            end
            if (due_item.item_kind == KIND_OUTCOME) outcome_seen[due_item.outcome]++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("Timed out after %0d cycles with %0d items outstanding.",
                  cycle_count, line_items_due.size());
         $display("login_name_line_editor_core verification failed");
         $finish;
      end
   end

   initial begin
      int row;
      int phase;
      int phase_start;
      logic [CH_W-1:0] erase_v;
      logic [CH_W-1:0] kill_v;

      req_bus.valid = 1'b0;
      req_bus.received_byte = '0;
      rsp_bus.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_ERASE;
      csr_wdata = '0;

      // Empty names, line ends with parity set, break, hangup, then editing.
      keystrokes[0]  = '{8'h0D, 1'b1, make_item(KIND_OUTCOME, '0, OUTC_RETRY, '0, 1'b1, 1'b0, 1'b1)};
      keystrokes[1]  = '{8'h8A, 1'b1, make_item(KIND_OUTCOME, '0, OUTC_RETRY, '0, 1'b0, 1'b0, 1'b1)};
      keystrokes[2]  = '{8'h80, 1'b1, make_item(KIND_OUTCOME, '0, OUTC_BREAK, '0, 1'b0, 1'b0, 1'b1)};
      keystrokes[3]  = '{8'h84, 1'b1, make_item(KIND_OUTCOME, '0, OUTC_HANGUP, '0, 1'b0, 1'b0, 1'b1)};
      keystrokes[4]  = '{8'h08, 1'b1, make_item(KIND_ECHO, 8'h88, '0, '0, 1'b0, 1'b0, 1'b1)};
      keystrokes[5]  = '{8'h41, 1'b1, make_item(KIND_ECHO, 8'h41, '0, '0, 1'b0, 1'b0, 1'b1)};
      keystrokes[6]  = '{8'hE2, 1'b1, make_item(KIND_ECHO, 8'hE2, '0, '0, 1'b0, 1'b0, 1'b1)};
      keystrokes[7]  = '{8'h7F, 1'b1, make_item(KIND_ECHO, 8'hFF, '0, '0, 1'b0, 1'b0, 1'b1)};
      keystrokes[8]  = '{8'h01, 1'b1, make_item(KIND_ECHO, 8'h81, '0, '0, 1'b0, 1'b0, 1'b1)};
      keystrokes[9]  = '{8'h40, 1'b0, '0};
      keystrokes[10] = '{8'h5A, 1'b0, '0};
      keystrokes[11] = '{8'h7A, 1'b0, '0};
      keystrokes[12] = '{8'h08, 1'b0, '0};
      keystrokes[13] = '{8'h3F, 1'b0, '0};
      keystrokes[14] = '{8'h0D, 1'b0, '0};
      keystrokes[15] = '{8'h58, 1'b0, '0};
      keystrokes[16] = '{8'hD9, 1'b0, '0};
      keystrokes[17] = '{8'h0A, 1'b0, '0};
      keystrokes[18] = '{8'h31, 1'b0, '0};
      keystrokes[19] = '{8'h04, 1'b1, make_item(KIND_OUTCOME, '0, OUTC_HANGUP, '0, 1'b0, 1'b0, 1'b1)};
      keystrokes[20] = '{8'h32, 1'b0, '0};
      keystrokes[21] = '{8'h0D, 1'b0, '0};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (row = 0; row < DIR_ROWS; row++)
         send_byte(keystrokes[row].in_byte, keystrokes[row].typed, keystrokes[row].want);
      req_bus.valid <= 1'b0;

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         wait_idle();
         erase_v = erase_plan[phase];
         kill_v  = kill_plan[phase];
         if (phase == NUM_PHASES - 1) begin
            erase_v = CH_W'($urandom_range(0, 127));
            kill_v  = CH_W'($urandom_range(0, 127));
         end
         set_registers(erase_v, kill_v);
         settings_used++;
         // The long hold-off lands while names are streaming in.
         if (phase == 1) hold_go <= 1'b1;
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            if ($urandom_range(0, 4) != 0) begin
               send_attempt();
            end else begin
               repeat ($urandom_range(1, 3))
                  send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
            end
         end
         req_bus.valid <= 1'b0;
      end

      wait_idle();
      if (line_items_due.size() != 0) mismatch_count++;

      $display("Sent %0d bytes under %0d register settings and checked %0d result items.",
               bytes_sent, settings_used, items_checked);
      $display("Names: %0d accepted, %0d retried; %0d breaks and %0d hangups.",
               outcome_seen[OUTC_ACCEPT], outcome_seen[OUTC_RETRY],
               outcome_seen[OUTC_BREAK], outcome_seen[OUTC_HANGUP]);
      if (mismatch_count == 0) begin
         $display("login_name_line_editor_core verification clean");
      end else begin
         $display("%0d mismatches in total.", mismatch_count);
         $display("login_name_line_editor_core verification failed");
      end
      $finish;
   end

endmodule
